// File: design/cia_pkg.sv
// shared types, opcodes and helper functions of the checked integer alu
`default_nettype none
package cia_pkg;

  localparam int unsigned WORD_W         = 64;
  localparam int unsigned MAX_WORD_BYTES = 8;
  localparam int unsigned DIV_STEPS      = WORD_W;
  localparam int unsigned MUL_LAT        = 3;
  localparam int unsigned HALF_W         = WORD_W / 2;

  typedef logic [3:0]        wbytes_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,  OP_OR   = 5'd5,  OP_AND  = 5'd6,  OP_XOR  = 5'd7,
    OP_SHL  = 5'd8,  OP_SHR  = 5'd9,  OP_LAND = 5'd10, OP_LOR  = 5'd11,
    OP_LT   = 5'd12, OP_GT   = 5'd13, OP_LE   = 5'd14, OP_GE   = 5'd15,
    OP_EQ   = 5'd16, OP_NE   = 5'd17, OP_NEG  = 5'd18, OP_LNOT = 5'd19,
    OP_NOT  = 5'd20, OP_PASS = 5'd21
  } op_e;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO   = 2'd1;
  localparam logic [1:0] ERR_MOD_NONPOS = 2'd2;

  typedef enum logic [1:0] {
    SEL_SIMPLE = 2'd0,
    SEL_MUL    = 2'd1,
    SEL_DIV    = 2'd2,
    SEL_MOD    = 2'd3
  } res_sel_e;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic               overflow_flag;
    logic [1:0]         error_code;
  } res_t;

  // side data that travels alongside the multiplier and divider
  typedef struct packed {
    word_t    simple;
    logic     ovf;
    logic [1:0] err;
    res_sel_e sel;
    logic     neg_res;
    wbytes_t  wb;
  } side_t;

  typedef struct packed {
    word_t rem;
    word_t dq;
  } div_step_t;

  function automatic word_t sext_word(input word_t v, input wbytes_t wb);
    case (wb)
      4'd1:    return {{56{v[7]}},  v[7:0]};
      4'd2:    return {{48{v[15]}}, v[15:0]};
      4'd3:    return {{40{v[23]}}, v[23:0]};
      4'd4:    return {{32{v[31]}}, v[31:0]};
      4'd5:    return {{24{v[39]}}, v[39:0]};
      4'd6:    return {{16{v[47]}}, v[47:0]};
      4'd7:    return {{8{v[55]}},  v[55:0]};
      default: return v;
    endcase
  endfunction

  function automatic word_t word_max(input wbytes_t wb);
    logic [6:0] bits;
    bits = {wb[3:0], 3'b000} - 7'd1;
    return (word_t'(1) << bits[5:0]) - word_t'(1);
  endfunction

  // one restoring division step: next dividend bit shifts into the remainder, quotient bit shifts in at the bottom
  function automatic div_step_t div_step(input word_t rem, input word_t dq, input word_t d);
    logic [65:0] diff;
    div_step_t   r;
    diff = {1'b0, rem, dq[63]} - {2'b00, d};
    if (diff[65]) begin
      r.rem = {rem[62:0], dq[63]};
    end else begin
      r.rem = diff[63:0];
    end
    r.dq = {dq[62:0], ~diff[65]};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/checked_integer_alu.sv
// checked integer alu top level: input register, alignment lines and result stage
// a start transfer passes the input register, the decode stage, the 64-stage divider and the result register
// throughput: one request per cycle, every stage is fully pipelined
// busy stays low; results cannot be held off by the receiver
// reset clears all valid bits and sets the word size to 8 bytes
`default_nettype none
module checked_integer_alu (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire cia_pkg::req_t req_i,
  output logic               done_o,
  output cia_pkg::res_t      result_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [3:0]    cfg_data_i
);
  import cia_pkg::*;

  localparam int unsigned MUL_DLY = DIV_STEPS - MUL_LAT;

  logic    [3:0] wb_cfg_q;
  wbytes_t wb_eff;
  logic    in_vld_q;
  req_t    in_q;
  wbytes_t in_wb_q;

  logic  f_vld, f_sdiff;
  side_t f_side;
  word_t f_mag_a, f_mag_b;

  word_t mul_val, quo, rem;
  logic  mul_ovf;

  side_t side_dl_q [DIV_STEPS];
  logic  vld_dl_q  [DIV_STEPS];
  word_t mval_dl_q [MUL_DLY];
  logic  movf_dl_q [MUL_DLY];

  side_t s_end;
  res_t  res_d, res_q;
  logic  done_q;
  word_t r_div;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_cfg_q <= 4'(MAX_WORD_BYTES);
    end else if (cfg_valid_i) begin
      wb_cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (wb_cfg_q == 4'd0) begin
      wb_eff = 4'd1;
    end else if (wb_cfg_q > 4'(MAX_WORD_BYTES)) begin
      wb_eff = 4'(MAX_WORD_BYTES);
    end else begin
      wb_eff = wb_cfg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= req_i;
    in_wb_q <= wb_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  cia_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_vld_q),
    .req_i       (in_q),
    .wb_i        (in_wb_q),
    .valid_o     (f_vld),
    .side_o      (f_side),
    .mag_a_o     (f_mag_a),
    .mag_b_o     (f_mag_b),
    .sign_diff_o (f_sdiff)
  );

  cia_mul u_mul (
    .clk_i       (clk_i),
    .mag_a_i     (f_mag_a),
    .mag_b_i     (f_mag_b),
    .sign_diff_i (f_sdiff),
    .wb_i        (f_side.wb),
    .value_o     (mul_val),
    .ovf_o       (mul_ovf)
  );

  cia_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (f_vld),
    .dividend_i  (f_mag_a),
    .divisor_i   (f_mag_b),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // side data and multiplier results wait for the divider
  always_ff @(posedge clk_i) begin
    side_dl_q[0] <= f_side;
    for (int i = 1; i < DIV_STEPS; i++) begin
      side_dl_q[i] <= side_dl_q[i-1];
    end
    mval_dl_q[0] <= mul_val;
    movf_dl_q[0] <= mul_ovf;
    for (int i = 1; i < MUL_DLY; i++) begin
      mval_dl_q[i] <= mval_dl_q[i-1];
      movf_dl_q[i] <= movf_dl_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        vld_dl_q[i] <= 1'b0;
      end
    end else begin
      vld_dl_q[0] <= f_vld;
      for (int i = 1; i < DIV_STEPS; i++) begin
        vld_dl_q[i] <= vld_dl_q[i-1];
      end
    end
  end

  always_comb begin
    s_end = side_dl_q[DIV_STEPS-1];
    r_div = (s_end.sel == SEL_MOD) ? rem : quo;
    res_d.overflow_flag = s_end.ovf;
    res_d.error_code    = s_end.err;
    case (s_end.sel)
      SEL_SIMPLE: res_d.result_value = s_end.simple;
      SEL_MUL: begin
        res_d.result_value  = mval_dl_q[MUL_DLY-1];
        res_d.overflow_flag = movf_dl_q[MUL_DLY-1];
      end
      SEL_DIV, SEL_MOD: begin
        res_d.result_value = sext_word(s_end.neg_res ? (word_t'(0) - r_div) : r_div,
                                       s_end.wb);
      end
      default: res_d.result_value = s_end.simple;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_dl_q[DIV_STEPS-1];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_ovf_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.overflow_flag && result_o.error_code != ERR_NONE))
    else $error("overflow and error reported together");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.error_code == ERR_NONE || result_o.error_code == ERR_DIV_ZERO
                || result_o.error_code == ERR_MOD_NONPOS))
    else $error("undefined error code");

  a_wb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q |-> (in_wb_q != 4'd0 && in_wb_q <= 4'(MAX_WORD_BYTES)))
    else $error("word size outside 1 to 8 bytes");

endmodule
`default_nettype wire

// File: design/cia_front.sv
// decode stage: simple operations, error checks and operand magnitudes
`default_nettype none
module cia_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire cia_pkg::req_t req_i,
  input  wire cia_pkg::wbytes_t wb_i,
  output logic               valid_o,
  output cia_pkg::side_t     side_o,
  output cia_pkg::word_t     mag_a_o,
  output cia_pkg::word_t     mag_b_o,
  output logic               sign_diff_o
);
  import cia_pkg::*;

  word_t a, b, r, sum, dif, neg, sx;
  logic  sa, sb, ovf;
  logic [1:0] err;
  res_sel_e sel;
  logic  neg_res;
  logic [5:0] sh;
  side_t side_d, side_q;
  word_t mag_a_d, mag_b_d, mag_a_q, mag_b_q;
  logic  sign_diff_q, valid_q;

  always_comb begin
    a   = req_i.operand_a;
    b   = req_i.operand_b;
    sa  = a[63];
    sb  = b[63];
    sh  = b[5:0];
    sum = a + b;
    dif = a - b;
    neg = word_t'(0) - a;
    sx  = sext_word(a, wb_i);
    r   = '0;
    ovf = 1'b0;
    err = ERR_NONE;
    sel = SEL_SIMPLE;
    neg_res = 1'b0;
    case (req_i.req_type)
      OP_ADD: begin
        r   = sext_word(sum, wb_i);
        ovf = (~(sa ^ sb) & (sa ^ sum[63])) | (r != sum);
      end
      OP_SUB: begin
        r   = sext_word(dif, wb_i);
        ovf = ((sa ^ sb) & (sa ^ dif[63])) | (r != dif);
      end
      OP_MUL: sel = SEL_MUL;
      OP_DIV: begin
        if (b == '0) begin
          err = ERR_DIV_ZERO;
          r   = sx;
        end else begin
          sel     = SEL_DIV;
          neg_res = sa ^ sb;
        end
      end
      OP_MOD: begin
        if (b == '0 || sb) begin
          err = ERR_MOD_NONPOS;
          r   = sx;
        end else begin
          sel     = SEL_MOD;
          neg_res = sa;
        end
      end
      OP_OR:   r = sext_word(a | b, wb_i);
      OP_AND:  r = sext_word(a & b, wb_i);
      OP_XOR:  r = sext_word(a ^ b, wb_i);
      OP_SHL:  r = sext_word(a << sh, wb_i);
      OP_SHR:  r = sext_word(word_t'($signed(a) >>> sh), wb_i);
      OP_LAND: r = word_t'(a != '0 && b != '0);
      OP_LOR:  r = word_t'(a != '0 || b != '0);
      OP_LT:   r = word_t'($signed(a) < $signed(b));
      OP_GT:   r = word_t'($signed(a) > $signed(b));
      OP_LE:   r = word_t'($signed(a) <= $signed(b));
      OP_GE:   r = word_t'($signed(a) >= $signed(b));
      OP_EQ:   r = word_t'(a == b);
      OP_NE:   r = word_t'(a != b);
      OP_NEG: begin
        r   = sext_word(neg, wb_i);
        ovf = (a == {1'b1, 63'd0}) | (r != neg);
      end
      OP_LNOT: r = word_t'(a == '0);
      OP_NOT:  r = sext_word(~a, wb_i);
      OP_PASS: r = a;
      default: r = '0;
    endcase
    side_d.simple  = r;
    side_d.ovf     = ovf;
    side_d.err     = err;
    side_d.sel     = sel;
    side_d.neg_res = neg_res;
    side_d.wb      = wb_i;
    mag_a_d = sa ? (word_t'(0) - a) : a;
    mag_b_d = sb ? (word_t'(0) - b) : b;
  end

  always_ff @(posedge clk_i) begin
    side_q      <= side_d;
    mag_a_q     <= mag_a_d;
    mag_b_q     <= mag_b_d;
    sign_diff_q <= sa ^ sb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o     = valid_q;
  assign side_o      = side_q;
  assign mag_a_o     = mag_a_q;
  assign mag_b_o     = mag_b_q;
  assign sign_diff_o = sign_diff_q;

endmodule
`default_nettype wire

// File: design/cia_mul.sv
// three-stage unsigned magnitude multiplier with signed word overflow check
`default_nettype none
module cia_mul (
  input  wire logic             clk_i,
  input  wire cia_pkg::word_t   mag_a_i,
  input  wire cia_pkg::word_t   mag_b_i,
  input  wire logic             sign_diff_i,
  input  wire cia_pkg::wbytes_t wb_i,
  output cia_pkg::word_t        value_o,
  output logic                  ovf_o
);
  import cia_pkg::*;

  word_t p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_q;
  logic  neg1_q, neg2_q;
  wbytes_t wb1_q, wb2_q;
  word_t lo, hi, lim, val_d, value_q;
  logic  negp, ovf_d, ovf_q;

  always_ff @(posedge clk_i) begin
    p00_q  <= word_t'(mag_a_i[HALF_W-1:0]) * word_t'(mag_b_i[HALF_W-1:0]);
    p01_q  <= word_t'(mag_a_i[HALF_W-1:0]) * word_t'(mag_b_i[WORD_W-1:HALF_W]);
    p10_q  <= word_t'(mag_a_i[WORD_W-1:HALF_W]) * word_t'(mag_b_i[HALF_W-1:0]);
    p11_q  <= word_t'(mag_a_i[WORD_W-1:HALF_W]) * word_t'(mag_b_i[WORD_W-1:HALF_W]);
    neg1_q <= sign_diff_i;
    wb1_q  <= wb_i;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {64'd0, p00_q} + ({64'd0, p01_q} << HALF_W)
            + ({64'd0, p10_q} << HALF_W) + {p11_q, 64'd0};
    neg2_q <= neg1_q;
    wb2_q  <= wb1_q;
  end

  always_comb begin
    lo    = prod_q[63:0];
    hi    = prod_q[127:64];
    negp  = neg2_q && (lo != '0);
    lim   = word_max(wb2_q) + word_t'(negp);
    ovf_d = (hi != '0) || (lo > lim);
    val_d = sext_word(neg2_q ? (word_t'(0) - lo) : lo, wb2_q);
  end

  always_ff @(posedge clk_i) begin
    value_q <= val_d;
    ovf_q   <= ovf_d;
  end

  assign value_o = value_q;
  assign ovf_o   = ovf_q;

endmodule
`default_nettype wire

// File: design/cia_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module cia_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire cia_pkg::word_t dividend_i,
  input  wire cia_pkg::word_t divisor_i,
  output cia_pkg::word_t      quotient_o,
  output cia_pkg::word_t      remainder_o
);
  import cia_pkg::*;

  word_t rem_q [DIV_STEPS];
  word_t dq_q  [DIV_STEPS];
  word_t d_q   [DIV_STEPS];
  logic  vld_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    word_t     rem_in, dq_in, d_in;
    logic      v_in;
    div_step_t st;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign d_in   = divisor_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign d_in   = d_q[k-1];
      assign v_in   = vld_q[k-1];
    end
    always_comb begin
      st = div_step(rem_in, dq_in, d_in);
    end
    always_ff @(posedge clk_i) begin
      rem_q[k] <= st.rem;
      dq_q[k]  <= st.dq;
      d_q[k]   <= d_in;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end
  end

  assign quotient_o  = dq_q[DIV_STEPS-1];
  assign remainder_o = rem_q[DIV_STEPS-1];

  // a finished remainder is always below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[DIV_STEPS-1] && d_q[DIV_STEPS-1] != '0) |->
      (rem_q[DIV_STEPS-1] < d_q[DIV_STEPS-1]))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire
